// ===== sv/csq_pkg.sv =====
`default_nettype none

package csq_pkg;

  // command codes of the cmd field
  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_ADVANCE = 3'd1;
  localparam logic [2:0] CMD_INSERT  = 3'd2;
  localparam logic [2:0] CMD_ATTACH  = 3'd3;
  localparam logic [2:0] CMD_REMOVE  = 3'd4;
  localparam logic [2:0] CMD_READ    = 3'd5;

  // status codes of a result
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_NOCUR = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic latch;     // capture the input beat
    logic exec;      // decode command, update cursor and count, arm the move
    logic shift;     // move one entry per cycle
    logic fill;      // write the new entry
    logic read;      // read the current entry
    logic load_out;  // load the result register
  } csq_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic shift_busy;
    logic fill_pend;
    logic out_free;
  } csq_sts_t;

endpackage

`default_nettype wire

// ===== sv/csq_ctrl.sv =====
`default_nettype none

module csq_ctrl
  import csq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire csq_sts_t sts_i,
  output csq_ctl_t      ctl_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_FILL  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl_o.exec = 1'b1;
        state_d    = ST_SHIFT;
      end
      ST_SHIFT: begin
        ctl_o.shift = 1'b1;
        if (!sts_i.shift_busy) begin
          state_d = sts_i.fill_pend ? ST_FILL : ST_READ;
        end
      end
      ST_FILL: begin
        ctl_o.fill = 1'b1;
        state_d    = ST_READ;
      end
      ST_READ: begin
        ctl_o.read = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register can take the beat
        if (sts_i.out_free) begin
          ctl_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_read_after_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !sts_i.shift_busy)
    else $error("entry read while a move is still in flight");

  a_fill_after_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> $past(state_q) == ST_SHIFT)
    else $error("new entry written without a completed move");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && sts_i.out_free) |=> (state_q == ST_IDLE))
    else $error("result handoff did not return to idle");

endmodule

`default_nettype wire

// ===== sv/csq_datapath.sv =====
`default_nettype none

module csq_datapath
  import csq_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int WORD_WIDTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire csq_ctl_t    ctl_i,
  output csq_sts_t         sts_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [63:0] entry_word_i,
  input  wire logic        out_stall_i,
  output logic             out_valid_o,
  output logic [63:0]      current_word_o,
  output logic             has_current_o,
  output logic [6:0]       item_count_o,
  output logic [1:0]       status_o
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic [WORD_WIDTH-1:0] mem [CAPACITY];
  logic [WORD_WIDTH-1:0] rd_data_q;

  logic [2:0]            cmd_q;
  logic [WORD_WIDTH-1:0] word_q;
  logic [CNT_W-1:0]      used_q, used_d;
  logic [CNT_W-1:0]      cur_q, cur_d;
  logic [1:0]            status_q, status_d;

  // move engine
  logic [CNT_W-1:0] mv_cnt_q, mv_cnt_d;
  logic [IDX_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [IDX_W-1:0] last_rd_q;
  logic             up_q, up_d;
  logic             pend_q;
  logic             fill_q, fill_d;
  logic [IDX_W-1:0] pos_q;
  logic [CNT_W-1:0] pos_d;

  logic                  cur_ok;
  logic                  full;
  logic                  we, re;
  logic [IDX_W-1:0]      waddr, raddr, wr_addr;
  logic [WORD_WIDTH-1:0] wdata;

  logic                  out_valid_q;
  logic [CNT_W+6:0]      cnt_ext;
  logic [WORD_WIDTH+63:0] word_ext;

  assign cur_ok = (cur_q < used_q);
  assign full   = (used_q >= CAP_C);

  // command decode, evaluated in the execute cycle
  always_comb begin
    cur_d    = cur_q;
    used_d   = used_q;
    status_d = STS_OK;
    mv_cnt_d = '0;
    rd_ptr_d = '0;
    up_d     = 1'b0;
    fill_d   = 1'b0;
    pos_d    = cur_q;
    case (cmd_q)
      CMD_START: begin
        cur_d = '0;
      end
      CMD_ADVANCE: begin
        if (cur_ok) begin
          cur_d = cur_q + 1'b1;
        end else begin
          status_d = STS_NOCUR;
        end
      end
      CMD_INSERT, CMD_ATTACH: begin
        if (full) begin
          status_d = STS_FULL;
        end else begin
          if (cmd_q == CMD_INSERT) begin
            pos_d = cur_ok ? cur_q : '0;
          end else begin
            pos_d = cur_ok ? CNT_W'(cur_q + 1'b1) : used_q;
          end
          cur_d    = pos_d;
          used_d   = used_q + 1'b1;
          mv_cnt_d = used_q - pos_d;
          rd_ptr_d = IDX_W'(used_q - 1'b1);
          up_d     = 1'b1;
          fill_d   = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (cur_ok) begin
          used_d   = used_q - 1'b1;
          mv_cnt_d = used_q - cur_q - 1'b1;
          rd_ptr_d = IDX_W'(cur_q + 1'b1);
        end else begin
          status_d = STS_NOCUR;
        end
      end
      default: begin
        // read and unused codes leave count and cursor as they are and report ok
      end
    endcase
  end

  // each moved entry is read, then written one slot over in the next cycle
  assign wr_addr = up_q ? IDX_W'(last_rd_q + 1'b1) : IDX_W'(last_rd_q - 1'b1);
  assign we      = (ctl_i.shift && pend_q) || ctl_i.fill;
  assign waddr   = ctl_i.fill ? pos_q : wr_addr;
  assign wdata   = ctl_i.fill ? word_q : rd_data_q;
  assign re      = (ctl_i.shift && (mv_cnt_q != '0)) || ctl_i.read;
  assign raddr   = ctl_i.read ? cur_q[IDX_W-1:0] : rd_ptr_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q  <= cmd_i;
      word_q <= entry_word_i[WORD_WIDTH-1:0];
    end
    if (ctl_i.exec) begin
      up_q  <= up_d;
      pos_q <= pos_d[IDX_W-1:0];
    end
    if (ctl_i.shift && (mv_cnt_q != '0)) begin
      last_rd_q <= rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      cur_q    <= '0;
      status_q <= STS_OK;
      mv_cnt_q <= '0;
      rd_ptr_q <= '0;
      pend_q   <= 1'b0;
      fill_q   <= 1'b0;
    end else begin
      if (ctl_i.exec) begin
        used_q   <= used_d;
        cur_q    <= cur_d;
        status_q <= status_d;
        mv_cnt_q <= mv_cnt_d;
        rd_ptr_q <= rd_ptr_d;
        pend_q   <= 1'b0;
        fill_q   <= fill_d;
      end else if (ctl_i.shift) begin
        pend_q <= (mv_cnt_q != '0);
        if (mv_cnt_q != '0) begin
          mv_cnt_q <= mv_cnt_q - 1'b1;
          rd_ptr_q <= up_q ? IDX_W'(rd_ptr_q - 1'b1) : IDX_W'(rd_ptr_q + 1'b1);
        end
      end else if (ctl_i.fill) begin
        fill_q <= 1'b0;
      end
    end
  end

  assign sts_o.shift_busy = (mv_cnt_q != '0) || pend_q;
  assign sts_o.fill_pend  = fill_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // result register
  assign cnt_ext  = {7'd0, used_q};
  assign word_ext = {64'd0, rd_data_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      has_current_o  <= cur_ok;
      current_word_o <= cur_ok ? word_ext[63:0] : 64'd0;
      item_count_o   <= cnt_ext[6:0];
      status_o       <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q <= CAP_C) && (cur_q <= used_q))
    else $error("count or cursor out of range");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.load_out && status_q == STS_FULL) |-> (used_q == CAP_C))
    else $error("full status reported on a store that is not full");

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> (waddr != raddr))
    else $error("read and write of the same entry in one cycle");

endmodule

`default_nettype wire

// ===== sv/cursor_sequence_store_top.sv =====
// ordered word store with a cursor, one command beat in, one result beat out
// a command runs through the execute, shift, fill (insert or attach only), read
// and done states; the shift state moves n entries when n move (n < CAPACITY)
// the next command is taken in the cycle after the result is loaded; the move
// walks the store one entry a cycle, the result register frees the input
// reset: count and cursor go to zero at once, store contents are left as is
`default_nettype none

module cursor_sequence_store_top
  import csq_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int WORD_WIDTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [63:0] entry_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      current_word_o,
  output logic             has_current_o,
  output logic [6:0]       item_count_o,
  output logic [1:0]       status_o
);

  csq_ctl_t ctl;
  csq_sts_t sts;

  csq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  csq_datapath #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .cmd_i          (cmd_i),
    .entry_word_i   (entry_word_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .current_word_o (current_word_o),
    .has_current_o  (has_current_o),
    .item_count_o   (item_count_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire

// ===== dv/cursor_sequence_store_checker.sv =====
module cursor_sequence_store_checker
  import csq_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int WORD_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  cmd_i,
  input  logic [63:0] entry_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] current_word_i,
  input  logic        has_current_i,
  input  logic [6:0]  item_count_i,
  input  logic [1:0]  status_i,
  output int          err_cnt_o,
  output int          pending_o,
  output int          result_cnt_o,
  output int          full_cnt_o,
  output int          nocur_cnt_o
);

  typedef struct packed {
    logic [63:0] word;
    logic        cur;
    logic [6:0]  cnt;
    logic [1:0]  sts;
  } cursor_view_t;

  localparam logic [63:0] WORD_MASK = {64{1'b1}} >> (64 - WORD_WIDTH);

  logic [63:0]  seq_words [CAPACITY];
  int           held;
  int           pos;
  cursor_view_t cursor_view_q[$];

  initial begin
    foreach (seq_words[k]) seq_words[k] = '0;
    err_cnt_o    = 0;
    pending_o    = 0;
    result_cnt_o = 0;
    full_cnt_o   = 0;
    nocur_cnt_o  = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %h expected %h", what, got, want);
    err_cnt_o++;
  endtask

  // apply one command to the shadow sequence and give the result it yields
  task automatic update_sequence(input logic [2:0] cmd, input logic [63:0] w,
                                 output cursor_view_t view);
    int k;
    logic [1:0] sts;
    sts = STS_OK;
    case (cmd)
      CMD_START: pos = 0;
      CMD_ADVANCE: begin
        if (pos < held) pos++;
        else sts = STS_NOCUR;
      end
      CMD_INSERT, CMD_ATTACH: begin
        if (held >= CAPACITY) begin
          sts = STS_FULL;
        end else begin
          // no current item: insert goes to the front, attach to the end
          if (pos >= held) pos = (cmd == CMD_INSERT) ? 0 : held;
          else if (cmd == CMD_ATTACH) pos++;
          for (k = held; k > pos; k--) seq_words[k] = seq_words[k-1];
          seq_words[pos] = w & WORD_MASK;
          held++;
        end
      end
      CMD_REMOVE: begin
        if (pos < held) begin
          for (k = pos; k + 1 < held; k++) seq_words[k] = seq_words[k+1];
          held--;
        end else begin
          sts = STS_NOCUR;
        end
      end
      default: ;
    endcase
    view.cur  = (pos < held);
    view.word = view.cur ? (seq_words[pos] & WORD_MASK) : '0;
    view.cnt  = held[6:0];
    view.sts  = sts;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cursor_view_t view;
    cursor_view_t want;
    if (!rst_ni) begin
      held = 0;
      pos  = 0;
      cursor_view_q.delete();
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        update_sequence(cmd_i, entry_word_i, view);
        cursor_view_q.push_back(view);
        if (view.sts == STS_FULL) full_cnt_o++;
        if (view.sts == STS_NOCUR) nocur_cnt_o++;
      end
      if (out_valid_i && !out_stall_i) begin
        result_cnt_o++;
        if (cursor_view_q.size() == 0) begin
          // result beat with nothing outstanding
          report_mismatch("unexpected result beat", current_word_i, 64'd0);
        end else begin
          want = cursor_view_q.pop_front();
          if (current_word_i !== want.word)
            report_mismatch("current_word", current_word_i, want.word);
          if (has_current_i !== want.cur)
            report_mismatch("has_current", 64'(has_current_i), 64'(want.cur));
          if (item_count_i !== want.cnt)
            report_mismatch("item_count", 64'(item_count_i), 64'(want.cnt));
          if (status_i !== want.sts)
            report_mismatch("status", 64'(status_i), 64'(want.sts));
        end
      end
      pending_o = cursor_view_q.size();
    end
  end

endmodule

// ===== dv/cursor_sequence_store_top_tb.sv =====
module cursor_sequence_store_top_tb;
  import csq_pkg::*;

  localparam int CAPACITY       = 64;
  localparam int WORD_WIDTH     = 64;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 40;
  localparam int TAIL_CYCLES    = 100;

  // codes 6 and 7 are not decoded and behave as read
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  localparam int MIX_GROW   = 0;
  localparam int MIX_SHRINK = 1;
  localparam int MIX_EVEN   = 2;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  cmd;
  logic [63:0] entry_word;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] current_word;
  logic        has_current;
  logic [6:0]  item_count;
  logic [1:0]  status;

  int err_cnt;
  int pending;
  int result_cnt;
  int full_cnt;
  int nocur_cnt;

  int   items_sent;
  int   idle_cycles;
  logic quiet;
  logic hold_req;

  cursor_sequence_store_top #(
    .CAPACITY  (CAPACITY),
    .WORD_WIDTH(WORD_WIDTH)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (cmd),
    .entry_word_i  (entry_word),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .current_word_o(current_word),
    .has_current_o (has_current),
    .item_count_o  (item_count),
    .status_o      (status)
  );

  cursor_sequence_store_checker #(
    .CAPACITY  (CAPACITY),
    .WORD_WIDTH(WORD_WIDTH)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .cmd_i         (cmd),
    .entry_word_i  (entry_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .current_word_i(current_word),
    .has_current_i (has_current),
    .item_count_i  (item_count),
    .status_i      (status),
    .err_cnt_o     (err_cnt),
    .pending_o     (pending),
    .result_cnt_o  (result_cnt),
    .full_cnt_o    (full_cnt),
    .nocur_cnt_o   (nocur_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // no-progress watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // result side: random stall, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall = !quiet && ($urandom_range(99) < 23);
      end
    end
  end

  function automatic logic [63:0] rand_word();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [2:0] pick_cmd(input int mix);
    int r;
    r = $urandom_range(99);
    if (r >= 98) return r[0] ? CMD_SPARE7 : CMD_SPARE6;
    case (mix)
      MIX_GROW: begin
        if (r < 45) return CMD_INSERT;
        if (r < 80) return CMD_ATTACH;
        if (r < 85) return CMD_REMOVE;
        if (r < 90) return CMD_START;
        if (r < 95) return CMD_ADVANCE;
      end
      MIX_SHRINK: begin
        if (r < 50) return CMD_REMOVE;
        if (r < 70) return CMD_START;
        if (r < 82) return CMD_ADVANCE;
        if (r < 87) return CMD_INSERT;
        if (r < 92) return CMD_ATTACH;
      end
      default: begin
        if (r < 20) return CMD_INSERT;
        if (r < 40) return CMD_ATTACH;
        if (r < 60) return CMD_REMOVE;
        if (r < 72) return CMD_START;
        if (r < 87) return CMD_ADVANCE;
      end
    endcase
    return CMD_READ;
  endfunction

  task automatic send_cmd(input logic [2:0] c, input logic [63:0] w);
    while (!quiet && ($urandom_range(99) < 23)) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    cmd        = c;
    entry_word = w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_random(input int mix, input int n);
    repeat (n) send_cmd(pick_cmd(mix), rand_word());
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    cmd         = CMD_READ;
    entry_word  = '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    items_sent  = 0;
    idle_cycles = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty store, front/end placement, walking off the end, removal
    send_cmd(CMD_READ,    '0);
    send_cmd(CMD_START,   '0);
    send_cmd(CMD_ADVANCE, '0);
    send_cmd(CMD_REMOVE,  '0);
    send_cmd(CMD_INSERT,  '1);
    send_cmd(CMD_ATTACH,  '0);
    send_cmd(CMD_INSERT,  64'h5555_5555_5555_5555);
    send_cmd(CMD_ATTACH,  64'hAAAA_AAAA_AAAA_AAAA);
    send_cmd(CMD_START,   '1);
    send_cmd(CMD_ADVANCE, '1);
    send_cmd(CMD_ADVANCE, '0);
    send_cmd(CMD_ADVANCE, '0);
    send_cmd(CMD_ADVANCE, '0);
    send_cmd(CMD_ADVANCE, '0);
    send_cmd(CMD_ATTACH,  64'h8000_0000_0000_0001);
    send_cmd(CMD_ADVANCE, '0);
    send_cmd(CMD_INSERT,  64'h0123_4567_89AB_CDEF);
    send_cmd(CMD_REMOVE,  '0);
    send_cmd(CMD_START,   '0);
    send_cmd(CMD_ADVANCE, '0);
    send_cmd(CMD_ADVANCE, '0);
    send_cmd(CMD_ADVANCE, '0);
    send_cmd(CMD_REMOVE,  '0);
    send_cmd(CMD_SPARE6,  '1);
    send_cmd(CMD_SPARE7,  '1);

    // random: fill up past full, drain, mixed, repeat
    send_random(MIX_GROW, 50);
    hold_req = 1'b1;
    send_random(MIX_GROW, 80);
    send_random(MIX_SHRINK, 160);
    wait_drained();
    quiet = 1'b1;
    send_random(MIX_EVEN, 60);
    quiet = 1'b0;
    send_random(MIX_EVEN, 20);
    send_random(MIX_GROW, 80);
    send_random(MIX_SHRINK, 60);
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("%0d commands driven, %0d results checked", items_sent, result_cnt);
    $display("full-store rejects %0d, no-current rejects %0d", full_cnt, nocur_cnt);
    if (err_cnt == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
